@@ rtl/gsra_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsra_pkg
// Shared types and constants of the growable stack region allocator.
// ----------------------------------------------------------------------------
package gsra_pkg;

  localparam int unsigned REQ_W    = 31;
  localparam int unsigned INIT_W   = 31;
  localparam int unsigned ADDR_O_W = 32;
  localparam int unsigned IDX_O_W  = 4;
  localparam int unsigned STAT_W   = 2;

  localparam logic [INIT_W-1:0] INIT_SIZE_RESET = 31'd4096;

  localparam logic KIND_ALLOC  = 1'b0;
  localparam logic KIND_REWIND = 1'b1;

  localparam logic [STAT_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_TABLE_FULL = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_POOL_FULL  = 2'd2;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_RD_CUR,
    ST_ROOM,
    ST_FIT,
    ST_BADDR,
    ST_BOFF,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_APP_MAX,
    ST_APP_ADD,
    ST_APP_CHK,
    ST_OUT
  } state_e;

endpackage

@@ rtl/gsra_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsra_req_if
// Request channel: allocate or rewind.
// ----------------------------------------------------------------------------
interface gsra_req_if;
  import gsra_pkg::*;

  logic             valid;
  logic             ready;
  logic             kind;
  logic [REQ_W-1:0] request_bytes;

  modport source (output valid, output kind, output request_bytes, input ready);
  modport sink   (input valid, input kind, input request_bytes, output ready);
endinterface

@@ rtl/gsra_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsra_rsp_if
// Result channel: address, region and status of one request.
// ----------------------------------------------------------------------------
interface gsra_rsp_if;
  import gsra_pkg::*;

  logic                valid;
  logic                ready;
  logic [ADDR_O_W-1:0] address;
  logic [IDX_O_W-1:0]  region_index;
  logic [STAT_W-1:0]   status;

  modport source (output valid, output address, output region_index, output status,
                  input ready);
  modport sink   (input valid, input address, input region_index, input status,
                  output ready);
endinterface

@@ rtl/gsra_cfg_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsra_cfg_if
// Configuration write channel for the initial region size.
// ----------------------------------------------------------------------------
interface gsra_cfg_if;
  import gsra_pkg::*;

  logic              valid;
  logic              ready;
  logic [INIT_W-1:0] initial_size;

  modport source (output valid, output initial_size, input ready);
  modport sink   (input valid, input initial_size, output ready);
endinterface

@@ rtl/gsra_alu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsra_alu
// Shared add/subtract unit; borrow flags a < b on subtract.
// ----------------------------------------------------------------------------
module gsra_alu #(
  parameter int unsigned W = 35
) (
  input  logic [W-1:0]      a_i,
  input  logic [W-1:0]      b_i,
  input  gsra_pkg::alu_op_e op_i,
  output logic [W-1:0]      res_o,
  output logic              borrow_o
);
  import gsra_pkg::*;

  logic         sub;
  logic [W:0]   sum;

  assign sub = (op_i == ALU_SUB);
  assign sum = {1'b0, a_i} + {1'b0, (sub ? ~b_i : b_i)} + {{W{1'b0}}, sub};

  assign res_o    = sum[W-1:0];
  assign borrow_o = sub & ~sum[W];
endmodule

@@ rtl/gsra_region_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsra_region_mem
// Region table: size and base per region, one write and one registered read.
// ----------------------------------------------------------------------------
module gsra_region_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned SW    = 33,
  parameter int unsigned BW    = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [SW-1:0] wsize_i,
  input  logic [BW-1:0] wbase_i,
  input  logic [AW-1:0] raddr_i,
  output logic [SW-1:0] rsize_o,
  output logic [BW-1:0] rbase_o
);
  logic [SW-1:0] size_mem [DEPTH];
  logic [BW-1:0] base_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      size_mem[waddr_i] <= wsize_i;
      base_mem[waddr_i] <= wbase_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rsize_o <= size_mem[raddr_i];
    rbase_o <= base_mem[raddr_i];
  end
endmodule

@@ rtl/growable_stack_region_allocator_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// growable_stack_region_allocator_top
// Bump allocator over a grow-only table of regions in a flat address space.
// ----------------------------------------------------------------------------
//  channel | dir | handshake   | payload
//  cfg_i   | in  | valid/ready | initial_size
//  req_i   | in  | valid/ready | kind, request_bytes
//  rsp_o   | out | valid/ready | address, region_index, status
//
// One request at a time. Rewind goes back to the start of region 0; a bump checks
// the room in the current region, then forms the address and advances the offset.
// A miss scans later regions, then appends one; the first item sets up region 0.
// Sizes, offsets and addresses use one shared adder; the table has one read port.
// Reset initialises the control registers, not the table; rows past the fill count are unused.
// A waiting result is held in the output register while the next beat is taken.
// ----------------------------------------------------------------------------
module growable_stack_region_allocator_top #(
  parameter int unsigned MAX_REGIONS = 16,
  parameter int unsigned ADDR_BITS   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gsra_cfg_if.sink    cfg_i,
  gsra_req_if.sink    req_i,
  gsra_rsp_if.source  rsp_o
);
  import gsra_pkg::*;

  localparam int unsigned IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int unsigned CW = $clog2(MAX_REGIONS + 1);
  localparam int unsigned SW = ADDR_BITS + 1;
  localparam int unsigned XW = (ADDR_BITS + 3 > 32) ? ADDR_BITS + 3 : 32;
  localparam logic [XW-1:0] PoolLim = XW'(1) << ADDR_BITS;

  state_e            state_q, state_d;
  logic [INIT_W-1:0] init_q;
  logic [CW-1:0]     count_q, count_d;
  logic [IW-1:0]     cur_q, cur_d;
  logic [SW-1:0]     off_q, off_d;
  logic [SW-1:0]     top_q, top_d;
  logic              kind_q, kind_d;
  logic [REQ_W-1:0]  req_q, req_d;
  logic [XW-1:0]     tmp_q, tmp_d;
  logic [XW-1:0]     grow_q, grow_d;
  logic [CW-1:0]     idx_q, idx_d;

  logic [ADDR_O_W-1:0] res_addr_q, res_addr_d;
  logic [IDX_O_W-1:0]  res_idx_q, res_idx_d;
  logic [STAT_W-1:0]   res_st_q, res_st_d;

  logic                ov_q;
  logic [ADDR_O_W-1:0] out_addr_q;
  logic [IDX_O_W-1:0]  out_idx_q;
  logic [STAT_W-1:0]   out_st_q;
  logic                load_out;

  logic                mem_we;
  logic [IW-1:0]       mem_waddr, mem_raddr;
  logic [SW-1:0]       mem_wsize, rd_size;
  logic [ADDR_BITS-1:0] mem_wbase, rd_base;

  logic [XW-1:0] alu_a, alu_b, alu_res;
  alu_op_e       alu_op;
  logic          alu_borrow;

  logic [XW-1:0] cur_wide, idx_wide, cnt_wide, base_wide, top_wide, req_wide, size_wide;
  logic [CW-1:0] last_cnt;

  assign cur_wide  = XW'(cur_q);
  assign idx_wide  = XW'(idx_q);
  assign cnt_wide  = XW'(count_q);
  assign base_wide = XW'(rd_base);
  assign top_wide  = XW'(top_q);
  assign req_wide  = XW'(req_q);
  assign size_wide = XW'(rd_size);
  assign last_cnt  = count_q - CW'(1);

  gsra_alu #(.W(XW)) u_alu (
    .a_i      (alu_a),
    .b_i      (alu_b),
    .op_i     (alu_op),
    .res_o    (alu_res),
    .borrow_o (alu_borrow)
  );

  gsra_region_mem #(
    .DEPTH (MAX_REGIONS),
    .AW    (IW),
    .SW    (SW),
    .BW    (ADDR_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wsize_i (mem_wsize),
    .wbase_i (mem_wbase),
    .raddr_i (mem_raddr),
    .rsize_o (rd_size),
    .rbase_o (rd_base)
  );

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = (state_q == ST_IDLE);

  assign rsp_o.valid        = ov_q;
  assign rsp_o.address      = out_addr_q;
  assign rsp_o.region_index = out_idx_q;
  assign rsp_o.status       = out_st_q;

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    cur_d      = cur_q;
    off_d      = off_q;
    top_d      = top_q;
    kind_d     = kind_q;
    req_d      = req_q;
    tmp_d      = tmp_q;
    grow_d     = grow_q;
    idx_d      = idx_q;
    res_addr_d = res_addr_q;
    res_idx_d  = res_idx_q;
    res_st_d   = res_st_q;
    load_out   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = count_q[IW-1:0];
    mem_wsize  = grow_q[SW-1:0];
    mem_wbase  = top_q[ADDR_BITS-1:0];
    mem_raddr  = cur_q;
    alu_a      = tmp_q;
    alu_b      = req_wide;
    alu_op     = ALU_SUB;

    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          kind_d = req_i.kind;
          req_d  = req_i.request_bytes;
          if (count_q == '0) begin
            state_d = ST_INIT;
          end else if (req_i.kind == KIND_REWIND) begin
            cur_d      = '0;
            off_d      = '0;
            res_addr_d = '0;
            res_idx_d  = '0;
            res_st_d   = STATUS_OK;
            state_d    = ST_OUT;
          end else begin
            state_d = ST_RD_CUR;
          end
        end
      end
      ST_INIT: begin
        // region 0 must fit inside the pool
        alu_a = PoolLim;
        alu_b = XW'(init_q);
        res_addr_d = '0;
        res_idx_d  = '0;
        if (alu_borrow) begin
          res_st_d = STATUS_POOL_FULL;
          state_d  = ST_OUT;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wsize = SW'(init_q);
          mem_wbase = '0;
          count_d   = CW'(1);
          cur_d     = '0;
          off_d     = '0;
          top_d     = SW'(init_q);
          res_st_d  = STATUS_OK;
          state_d   = (kind_q == KIND_REWIND) ? ST_OUT : ST_RD_CUR;
        end
      end
      ST_RD_CUR: begin
        state_d = ST_ROOM;
      end
      ST_ROOM: begin
        alu_a   = size_wide;
        alu_b   = XW'(off_q);
        tmp_d   = alu_res;
        state_d = ST_FIT;
      end
      ST_FIT: begin
        if (!alu_borrow) begin
          state_d = ST_BADDR;
        end else begin
          idx_d   = CW'(cur_q) + CW'(1);
          state_d = ST_SCAN_RD;
        end
      end
      ST_BADDR: begin
        alu_a      = base_wide;
        alu_b      = XW'(off_q);
        alu_op     = ALU_ADD;
        res_addr_d = alu_res[ADDR_O_W-1:0];
        state_d    = ST_BOFF;
      end
      ST_BOFF: begin
        alu_a     = XW'(off_q);
        alu_op    = ALU_ADD;
        off_d     = alu_res[SW-1:0];
        res_idx_d = cur_wide[IDX_O_W-1:0];
        res_st_d  = STATUS_OK;
        state_d   = ST_OUT;
      end
      ST_SCAN_RD: begin
        if (idx_q < count_q) begin
          mem_raddr = idx_q[IW-1:0];
          state_d   = ST_SCAN_CMP;
        end else if (count_q == CW'(MAX_REGIONS)) begin
          res_addr_d = '0;
          res_idx_d  = '0;
          res_st_d   = STATUS_TABLE_FULL;
          state_d    = ST_OUT;
        end else begin
          // fetch the last region for the growth size
          mem_raddr = last_cnt[IW-1:0];
          state_d   = ST_APP_MAX;
        end
      end
      ST_SCAN_CMP: begin
        alu_a = size_wide;
        if (!alu_borrow) begin
          cur_d      = idx_q[IW-1:0];
          off_d      = SW'(req_q);
          res_addr_d = base_wide[ADDR_O_W-1:0];
          res_idx_d  = idx_wide[IDX_O_W-1:0];
          res_st_d   = STATUS_OK;
          state_d    = ST_OUT;
        end else begin
          idx_d   = idx_q + CW'(1);
          state_d = ST_SCAN_RD;
        end
      end
      ST_APP_MAX: begin
        alu_a   = size_wide;
        grow_d  = (alu_borrow ? req_wide : size_wide) << 1;
        state_d = ST_APP_ADD;
      end
      ST_APP_ADD: begin
        alu_a   = top_wide;
        alu_b   = grow_q;
        alu_op  = ALU_ADD;
        tmp_d   = alu_res;
        state_d = ST_APP_CHK;
      end
      ST_APP_CHK: begin
        // new pool top must not pass the end of the address space
        alu_a = PoolLim;
        alu_b = tmp_q;
        if (alu_borrow) begin
          res_addr_d = '0;
          res_idx_d  = '0;
          res_st_d   = STATUS_POOL_FULL;
        end else begin
          mem_we     = 1'b1;
          top_d      = tmp_q[SW-1:0];
          count_d    = count_q + CW'(1);
          cur_d      = count_q[IW-1:0];
          off_d      = SW'(req_q);
          res_addr_d = top_wide[ADDR_O_W-1:0];
          res_idx_d  = cnt_wide[IDX_O_W-1:0];
          res_st_d   = STATUS_OK;
        end
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!ov_q || rsp_o.ready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      init_q  <= INIT_SIZE_RESET;
      count_q <= '0;
      cur_q   <= '0;
      off_q   <= '0;
      top_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      cur_q   <= cur_d;
      off_q   <= off_d;
      top_q   <= top_d;
      if (cfg_i.valid) begin
        init_q <= cfg_i.initial_size;
      end
      if (load_out) begin
        ov_q <= 1'b1;
      end else if (rsp_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    req_q      <= req_d;
    tmp_q      <= tmp_d;
    grow_q     <= grow_d;
    idx_q      <= idx_d;
    res_addr_q <= res_addr_d;
    res_idx_q  <= res_idx_d;
    res_st_q   <= res_st_d;
    if (load_out) begin
      out_addr_q <= res_addr_q;
      out_idx_q  <= res_idx_q;
      out_st_q   <= res_st_q;
    end
  end

`ifndef SYNTH
  a_cur_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) |-> (CW'(cur_q) < count_q))
    else $error("current region outside the filled table");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_REGIONS))
    else $error("region count beyond table depth");

  a_top_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    XW'(top_q) <= PoolLim)
    else $error("pool top beyond address space");

  a_rsp_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> $past(state_q == ST_OUT))
    else $error("result raised outside the output state");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && out_st_q != STATUS_OK) |-> (out_addr_q == '0 && out_idx_q == '0))
    else $error("error result carries a nonzero address or region");
`endif

endmodule
